@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, sampled on clk_i and off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define PCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen
`define PCD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ src/pcd_pkg.sv @@
// ----------------------------------------------------------------------------
// pcd_pkg
// types and constants of the pointer click/drag recognizer
// ----------------------------------------------------------------------------
package pcd_pkg;

  localparam int ID_BITS    = 16;
  localparam int COORD_BITS = 12;
  localparam int KEY_BITS   = 9;
  localparam int TOT_BITS   = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int D2_BITS    = SQ_BITS + 1;
  localparam int NBTN       = 3;
  localparam int BTN_BITS   = 2;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = 12;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLED = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SLOP    = 1'd1;

  localparam logic [BTN_BITS-1:0] BTN_LEFT   = 2'd0;
  localparam logic [BTN_BITS-1:0] BTN_MIDDLE = 2'd2;

  typedef enum logic [3:0] {
    EV_PRESSED    = 4'd0,
    EV_RELEASED   = 4'd1,
    EV_DRAG_START = 4'd2,
    EV_DRAG_END   = 4'd3,
    EV_CLICKED    = 4'd4,
    EV_FOCUSED    = 4'd5,
    EV_UNFOCUSED  = 4'd6,
    EV_SCROLLED   = 4'd7,
    EV_KEY_DOWN   = 4'd8,
    EV_KEY_UP     = 4'd9,
    EV_FRAME_DONE = 4'd10
  } ev_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_KEY, ST_PRESS, ST_UNFOC, ST_FOC, ST_MUL,
    ST_DRAG, ST_REL, ST_END, ST_SCROLL, ST_DONE
  } step_e;

  // classified word handed from front to back
  typedef struct packed {
    logic                  is_key;
    logic                  key_down;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [NBTN-1:0]       lv;
    logic [NBTN-1:0]       pr;
    logic [NBTN-1:0]       rl;
    logic                  hv;
    logic [ID_BITS-1:0]    hid;
    logic                  scr;
  } item_t;

endpackage

@@ src/pcd_front.sv @@
// ----------------------------------------------------------------------------
// pcd_front
// accepts input words, finds button edges and filters key repeats
// ----------------------------------------------------------------------------
module pcd_front import pcd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  enabled_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  action_i,
  input  logic [COORD_BITS-1:0] pointer_x_i,
  input  logic [COORD_BITS-1:0] pointer_y_i,
  input  logic                  left_level_i,
  input  logic                  right_level_i,
  input  logic                  middle_level_i,
  input  logic                  ui_captured_i,
  input  logic                  hit_valid_i,
  input  logic [ID_BITS-1:0]    hit_id_i,
  input  logic                  scrolled_i,
  input  logic [KEY_BITS-1:0]   key_code_i,
  input  logic                  key_level_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output item_t                 item_o
);

  logic [NBTN-1:0]     prev_q, prev_d;
  logic                held_q, held_d;
  logic [KEY_BITS-1:0] code_q, code_d;
  logic                blind, acc, keep;
  logic [NBTN-1:0]     lv;

  assign in_ready_o = !q_full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign blind      = !enabled_i || ui_captured_i;
  assign lv = blind ? '0 : {middle_level_i, right_level_i, left_level_i};

  always_comb begin
    prev_d = prev_q;
    held_d = held_q;
    code_d = code_q;
    keep   = 1'b0;
    item_o          = '0;
    item_o.is_key   = action_i;
    item_o.key_down = key_level_i;
    item_o.px       = pointer_x_i;
    item_o.py       = pointer_y_i;
    if (action_i) begin
      // repeated key-down and keys while disabled give nothing
      keep = enabled_i && !(key_level_i && held_q && key_code_i == code_q);
      if (acc && keep) begin
        held_d = key_level_i;
        code_d = key_code_i;
      end
    end else begin
      keep       = 1'b1;
      item_o.lv  = lv;
      item_o.pr  = lv & ~prev_q;
      item_o.rl  = ~lv & prev_q;
      item_o.hv  = !blind && hit_valid_i;
      item_o.hid = item_o.hv ? hit_id_i : '0;
      item_o.scr = !blind && scrolled_i;
      if (acc) prev_d = lv;
    end
  end

  assign push_o = acc && keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      held_q <= 1'b0;
      code_q <= '0;
    end else begin
      prev_q <= prev_d;
      held_q <= held_d;
      code_q <= code_d;
    end
  end

endmodule

@@ src/pcd_queue.sv @@
// ----------------------------------------------------------------------------
// pcd_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module pcd_queue import pcd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  output logic  valid_o,
  input  logic  pop_i,
  output item_t item_o
);
  `include "assert_macros.svh"

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  `PCD_NEVER(a_cnt_range, cnt_q == 2'd3, "queue count out of range")
  `PCD_NEVER(a_push_full, push_i && full_o, "push into full queue")

endmodule

@@ src/pcd_back.sv @@
// ----------------------------------------------------------------------------
// pcd_back
// per-button sequencer: updates gesture state and emits events one by one
// ----------------------------------------------------------------------------
module pcd_back import pcd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [CFG_DATA_BITS-1:0]   slop_i,
  input  logic                       q_valid_i,
  input  item_t                      q_item_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [3:0]                 event_kind_o,
  output logic [BTN_BITS-1:0]        button_o,
  output logic                       subject_valid_o,
  output logic [ID_BITS-1:0]         subject_id_o,
  output logic signed [TOT_BITS-1:0] drag_total_x_o,
  output logic signed [TOT_BITS-1:0] drag_total_y_o,
  output logic                       last_o
);
  `include "assert_macros.svh"

  step_e               step_q, step_d;
  logic [BTN_BITS-1:0] b_q, b_d;
  item_t               cur_q;

  logic [COORD_BITS-1:0] ppx_q [NBTN];
  logic [COORD_BITS-1:0] ppy_q [NBTN];
  logic [ID_BITS-1:0]    pobj_q [NBTN];
  logic [NBTN-1:0]       pv_q, drag_q;
  logic                  fv_q;
  logic [ID_BITS-1:0]    fobj_q;
  logic                  differs_q;
  logic signed [TOT_BITS-1:0] dx_q, dy_q, tx_q, ty_q;
  logic [SQ_BITS-1:0]    dx2_q, dy2_q, slop2_q;

  logic signed [TOT_BITS-1:0]   dx_d, dy_d;
  logic signed [2*TOT_BITS-1:0] dx_p, dy_p;
  logic [D2_BITS-1:0]           d2;

  logic                       want, fire, out_free, lst;
  ev_kind_e                   kind;
  logic [BTN_BITS-1:0]        btn;
  logic                       sv;
  logic [ID_BITS-1:0]         sid;
  logic signed [TOT_BITS-1:0] ox, oy;

  logic                       ov_q;
  ev_kind_e                   okind_q;
  logic [BTN_BITS-1:0]        obtn_q;
  logic                       osv_q, olast_q;
  logic [ID_BITS-1:0]         osid_q;
  logic signed [TOT_BITS-1:0] ox_q, oy_q;

  logic cond_drag, click;

  assign out_free = !ov_q || out_ready_i;

  assign dx_d = $signed({1'b0, cur_q.px}) - $signed({1'b0, ppx_q[b_q]});
  assign dy_d = $signed({1'b0, cur_q.py}) - $signed({1'b0, ppy_q[b_q]});
  assign dx_p = dx_d * dx_d;
  assign dy_p = dy_d * dy_d;
  assign d2   = {1'b0, dx2_q} + {1'b0, dy2_q};

  assign cond_drag = cur_q.lv[b_q] && pv_q[b_q];
  assign click = pv_q[b_q] && cur_q.hv && pobj_q[b_q] == cur_q.hid;

  // step sequencing and the event each step may emit
  always_comb begin
    step_d = step_q;
    b_d    = b_q;
    want   = 1'b0;
    kind   = EV_FRAME_DONE;
    btn    = b_q;
    sv     = 1'b0;
    sid    = '0;
    ox     = '0;
    oy     = '0;
    lst    = 1'b0;
    pop_o  = 1'b0;
    case (step_q)
      ST_IDLE: begin
        pop_o = q_valid_i;
        if (q_valid_i) begin
          step_d = q_item_i.is_key ? ST_KEY : ST_PRESS;
          b_d    = BTN_LEFT;
        end
      end
      ST_KEY: begin
        want   = 1'b1;
        kind   = cur_q.key_down ? EV_KEY_DOWN : EV_KEY_UP;
        btn    = BTN_LEFT;
        sv     = fv_q;
        sid    = fobj_q;
        lst    = 1'b1;
        step_d = ST_IDLE;
      end
      ST_PRESS: begin
        want   = cur_q.pr[b_q] && cur_q.hv;
        kind   = EV_PRESSED;
        sv     = 1'b1;
        sid    = cur_q.hid;
        step_d = (b_q == BTN_LEFT && cur_q.pr[b_q]) ? ST_UNFOC : ST_MUL;
      end
      ST_UNFOC: begin
        want   = differs_q && fv_q;
        kind   = EV_UNFOCUSED;
        btn    = BTN_LEFT;
        sv     = 1'b1;
        sid    = fobj_q;
        step_d = ST_FOC;
      end
      ST_FOC: begin
        want   = differs_q && cur_q.hv;
        kind   = EV_FOCUSED;
        btn    = BTN_LEFT;
        sv     = 1'b1;
        sid    = cur_q.hid;
        step_d = ST_MUL;
      end
      ST_MUL: step_d = ST_DRAG;
      ST_DRAG: begin
        want   = cond_drag && !drag_q[b_q] && d2 > {1'b0, slop2_q};
        kind   = EV_DRAG_START;
        sv     = 1'b1;
        sid    = pobj_q[b_q];
        step_d = ST_REL;
      end
      ST_REL: begin
        want   = cur_q.rl[b_q] && pv_q[b_q];
        kind   = EV_RELEASED;
        sv     = 1'b1;
        sid    = pobj_q[b_q];
        step_d = ST_END;
      end
      ST_END: begin
        want = cur_q.rl[b_q] && (drag_q[b_q] || click);
        kind = drag_q[b_q] ? EV_DRAG_END : EV_CLICKED;
        sv   = drag_q[b_q] ? pv_q[b_q] : 1'b1;
        sid  = pv_q[b_q] ? pobj_q[b_q] : '0;
        if (b_q == BTN_MIDDLE) begin
          step_d = ST_SCROLL;
        end else begin
          step_d = ST_PRESS;
          b_d    = b_q + 2'd1;
        end
      end
      ST_SCROLL: begin
        want   = cur_q.scr;
        kind   = EV_SCROLLED;
        btn    = BTN_LEFT;
        sv     = cur_q.hv;
        sid    = cur_q.hid;
        step_d = ST_DONE;
      end
      ST_DONE: begin
        want   = 1'b1;
        kind   = EV_FRAME_DONE;
        btn    = BTN_LEFT;
        ox     = tx_q;
        oy     = ty_q;
        lst    = 1'b1;
        step_d = ST_IDLE;
      end
      default: step_d = ST_IDLE;
    endcase
    fire = (step_q != ST_IDLE) && (!want || out_free);
    if (step_q != ST_IDLE && !fire) begin
      step_d = step_q;
      b_d    = b_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
      b_q    <= BTN_LEFT;
    end else begin
      step_q <= step_d;
      b_q    <= b_d;
    end
  end

  // payload side, no reset needed
  always_ff @(posedge clk_i) begin
    slop2_q <= slop_i * slop_i;
    if (pop_o) cur_q <= q_item_i;
    if (fire && step_q == ST_PRESS && cur_q.pr[b_q]) pobj_q[b_q] <= cur_q.hid;
    if (fire && step_q == ST_MUL) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      dx2_q <= dx_p[SQ_BITS-1:0];
      dy2_q <= dy_p[SQ_BITS-1:0];
    end
    if (want && fire) begin
      okind_q <= kind;
      obtn_q  <= btn;
      osv_q   <= sv;
      osid_q  <= sv ? sid : '0;
      ox_q    <= ox;
      oy_q    <= oy;
      olast_q <= lst;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppx_q     <= '{default: '0};
      ppy_q     <= '{default: '0};
      pv_q      <= '0;
      drag_q    <= '0;
      fv_q      <= 1'b0;
      fobj_q    <= '0;
      differs_q <= 1'b0;
      tx_q      <= '0;
      ty_q      <= '0;
      ov_q      <= 1'b0;
    end else begin
      if (pop_o) begin
        tx_q <= '0;
        ty_q <= '0;
      end
      if (fire) begin
        case (step_q)
          ST_PRESS: begin
            if (cur_q.pr[b_q]) begin
              ppx_q[b_q]  <= cur_q.px;
              ppy_q[b_q]  <= cur_q.py;
              pv_q[b_q]   <= cur_q.hv;
              drag_q[b_q] <= 1'b0;
            end
            differs_q <= (cur_q.hv != fv_q) || (cur_q.hv && cur_q.hid != fobj_q);
          end
          ST_FOC: begin
            if (differs_q) begin
              fv_q   <= cur_q.hv;
              fobj_q <= cur_q.hid;
            end
          end
          ST_DRAG: begin
            if (cond_drag && b_q == BTN_LEFT) begin
              tx_q <= dx_q;
              ty_q <= dy_q;
            end
            if (want) drag_q[b_q] <= 1'b1;
          end
          ST_END: begin
            if (cur_q.rl[b_q]) begin
              pv_q[b_q]   <= 1'b0;
              drag_q[b_q] <= 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (want && fire)      ov_q <= 1'b1;
      else if (out_ready_i)  ov_q <= 1'b0;
    end
  end

  assign out_valid_o     = ov_q;
  assign event_kind_o    = okind_q;
  assign button_o        = obtn_q;
  assign subject_valid_o = osv_q;
  assign subject_id_o    = osid_q;
  assign drag_total_x_o  = ox_q;
  assign drag_total_y_o  = oy_q;
  assign last_o          = olast_q;

  `PCD_ASSERT(a_last_kind, (ov_q && olast_q) |-> (okind_q == EV_FRAME_DONE ||
    okind_q == EV_KEY_DOWN || okind_q == EV_KEY_UP), "last on wrong event")
  `PCD_ASSERT(a_tot_done, (ov_q && okind_q != EV_FRAME_DONE) |->
    (ox_q == '0 && oy_q == '0), "drag total outside frame done")
  `PCD_ASSERT(a_drag_pv, (step_q == ST_PRESS) |-> ((drag_q & ~pv_q) == '0),
    "drag without pressed object")

endmodule

@@ src/pointer_click_drag_recognizer.sv @@
// the back pops each word in its idle step; a key word then runs its key step, while a
// pointer frame runs five steps per button, two focus steps on a left press, then
// scroll and done; each event word is registered before it reaches the outputs
// the front keeps accepting into a two-entry queue while the back works; output stalls hold it
// reset: asynchronous active low; clears gesture, focus, key and queue state, enabled=1, slop=4
// ----------------------------------------------------------------------------
// pointer_click_drag_recognizer
// click, drag, focus and key event recognizer for one pointer channel
// ----------------------------------------------------------------------------
module pointer_click_drag_recognizer import pcd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       action_i,
  input  logic [COORD_BITS-1:0]      pointer_x_i,
  input  logic [COORD_BITS-1:0]      pointer_y_i,
  input  logic                       left_level_i,
  input  logic                       right_level_i,
  input  logic                       middle_level_i,
  input  logic                       ui_captured_i,
  input  logic                       hit_valid_i,
  input  logic [ID_BITS-1:0]         hit_id_i,
  input  logic                       scrolled_i,
  input  logic [KEY_BITS-1:0]        key_code_i,
  input  logic                       key_level_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [3:0]                 event_kind_o,
  output logic [BTN_BITS-1:0]        button_o,
  output logic                       subject_valid_o,
  output logic [ID_BITS-1:0]         subject_id_o,
  output logic signed [TOT_BITS-1:0] drag_total_x_o,
  output logic signed [TOT_BITS-1:0] drag_total_y_o,
  output logic                       last_o
);

  logic                     enabled_q;
  logic [CFG_DATA_BITS-1:0] slop_q;
  logic  q_full, q_valid, push, pop;
  item_t f_item, q_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b1;
      slop_q    <= CFG_DATA_BITS'(4);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ENABLED: enabled_q <= cfg_data_i[0];
        CFG_SLOP:    slop_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pcd_front u_front (
    .clk_i, .rst_ni,
    .enabled_i (enabled_q),
    .in_valid_i, .in_ready_o,
    .action_i, .pointer_x_i, .pointer_y_i,
    .left_level_i, .right_level_i, .middle_level_i,
    .ui_captured_i, .hit_valid_i, .hit_id_i, .scrolled_i,
    .key_code_i, .key_level_i,
    .q_full_i  (q_full),
    .push_o    (push),
    .item_o    (f_item)
  );

  pcd_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .item_o  (q_item)
  );

  pcd_back u_back (
    .clk_i, .rst_ni,
    .slop_i    (slop_q),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .pop_o     (pop),
    .out_valid_o, .out_ready_i,
    .event_kind_o, .button_o, .subject_valid_o, .subject_id_o,
    .drag_total_x_o, .drag_total_y_o, .last_o
  );

endmodule

@@ verif/pointer_click_drag_recognizer_tb.sv @@
// ----------------------------------------------------------------------------
// pointer_click_drag_recognizer_tb
// self-checking bench: pointer frames and key words go in on a valid/ready
// channel, a behavioral gesture predictor builds the expected events, and a
// checker compares every event word with the oldest expectation
// ----------------------------------------------------------------------------
module pointer_click_drag_recognizer_tb;
  import pcd_pkg::*;

  typedef struct {
    bit                    act;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    bit   [NBTN-1:0]       lv;
    bit                    cap;
    bit                    hv;
    logic [ID_BITS-1:0]    hid;
    bit                    scr;
    logic [KEY_BITS-1:0]   kc;
    bit                    kl;
  } word_t;

  typedef struct {
    ev_kind_e                   kind;
    logic [BTN_BITS-1:0]        btn;
    logic                       sv;
    logic [ID_BITS-1:0]         sid;
    logic signed [TOT_BITS-1:0] dx;
    logic signed [TOT_BITS-1:0] dy;
    logic                       last;
  } gesture_ev_t;

  logic                       clk_i = 0;
  logic                       rst_ni = 0;
  logic                       cfg_valid_i = 0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]    cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0]   cfg_data_i = '0;
  logic                       in_valid_i = 0;
  logic                       in_ready_o;
  logic                       action_i = 0;
  logic [COORD_BITS-1:0]      pointer_x_i = '0;
  logic [COORD_BITS-1:0]      pointer_y_i = '0;
  logic                       left_level_i = 0;
  logic                       right_level_i = 0;
  logic                       middle_level_i = 0;
  logic                       ui_captured_i = 0;
  logic                       hit_valid_i = 0;
  logic [ID_BITS-1:0]         hit_id_i = '0;
  logic                       scrolled_i = 0;
  logic [KEY_BITS-1:0]        key_code_i = '0;
  logic                       key_level_i = 0;
  logic                       out_valid_o;
  logic                       out_ready_i = 0;
  logic [3:0]                 event_kind_o;
  logic [BTN_BITS-1:0]        button_o;
  logic                       subject_valid_o;
  logic [ID_BITS-1:0]         subject_id_o;
  logic signed [TOT_BITS-1:0] drag_total_x_o;
  logic signed [TOT_BITS-1:0] drag_total_y_o;
  logic                       last_o;

  pointer_click_drag_recognizer dut (.*);

  // predictor state
  bit                    cfg_en = 1;
  logic [11:0]           cfg_slop = 12'd4;
  bit                    prev_btn [NBTN];
  logic [COORD_BITS-1:0] press_x [NBTN];
  logic [COORD_BITS-1:0] press_y [NBTN];
  logic [ID_BITS-1:0]    press_obj [NBTN];
  bit                    press_ok [NBTN];
  bit                    dragging [NBTN];
  logic [ID_BITS-1:0]    focus_id = '0;
  bit                    focus_ok = 0;
  bit                    key_held = 0;
  logic [KEY_BITS-1:0]   held_code = '0;

  gesture_ev_t pending_events[$];
  int          errors = 0;
  bit          steady = 0;
  bit          hold_req = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("pointer_click_drag_recognizer_tb failed");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic void add_event(ev_kind_e k, logic [BTN_BITS-1:0] b, logic sv,
                                    logic [ID_BITS-1:0] sid,
                                    logic signed [TOT_BITS-1:0] dx,
                                    logic signed [TOT_BITS-1:0] dy, logic lst);
    gesture_ev_t e;
    e.kind = k; e.btn = b; e.sv = sv; e.sid = sv ? sid : '0;
    e.dx = dx; e.dy = dy; e.last = lst;
    pending_events.insert(pending_events.size(), e);
  endfunction

  function automatic void predict_events(word_t w);
    bit blind, hv, scr, lv, pr, rl, differs, pv;
    logic [ID_BITS-1:0] hid, po;
    longint slop2, d2;
    int dx, dy;
    logic signed [TOT_BITS-1:0] tx, ty;
    if (w.act) begin
      if (!cfg_en) return;
      if (w.kl && key_held && w.kc == held_code) return;
      held_code = w.kc;
      key_held = w.kl;
      if (w.kl) add_event(EV_KEY_DOWN, '0, focus_ok, focus_id, '0, '0, 1);
      else add_event(EV_KEY_UP, '0, focus_ok, focus_id, '0, '0, 1);
      return;
    end
    blind = !cfg_en || w.cap;
    hv = !blind && w.hv;
    hid = hv ? w.hid : '0;
    scr = !blind && w.scr;
    slop2 = longint'(cfg_slop) * longint'(cfg_slop);
    tx = '0;
    ty = '0;
    for (int b = 0; b < NBTN; b++) begin
      lv = !blind && w.lv[b];
      pr = lv && !prev_btn[b];
      rl = !lv && prev_btn[b];
      if (pr) begin
        press_x[b] = w.x;
        press_y[b] = w.y;
        press_ok[b] = hv;
        press_obj[b] = hid;
        dragging[b] = 0;
        if (hv) add_event(EV_PRESSED, BTN_BITS'(b), 1, hid, '0, '0, 0);
        if (b == BTN_LEFT) begin
          differs = (hv != focus_ok) || (hv && hid != focus_id);
          if (differs) begin
            if (focus_ok) add_event(EV_UNFOCUSED, '0, 1, focus_id, '0, '0, 0);
            focus_ok = hv;
            focus_id = hid;
            if (hv) add_event(EV_FOCUSED, '0, 1, hid, '0, '0, 0);
          end
        end
      end
      if (lv && press_ok[b]) begin
        dx = int'(w.x) - int'(press_x[b]);
        dy = int'(w.y) - int'(press_y[b]);
        d2 = longint'(dx) * dx + longint'(dy) * dy;
        if (b == BTN_LEFT) begin
          tx = TOT_BITS'(dx);
          ty = TOT_BITS'(dy);
        end
        if (!dragging[b] && d2 > slop2) begin
          dragging[b] = 1;
          add_event(EV_DRAG_START, BTN_BITS'(b), 1, press_obj[b], '0, '0, 0);
        end
      end
      if (rl) begin
        pv = press_ok[b];
        po = pv ? press_obj[b] : '0;
        if (pv) add_event(EV_RELEASED, BTN_BITS'(b), 1, po, '0, '0, 0);
        if (dragging[b]) add_event(EV_DRAG_END, BTN_BITS'(b), pv, po, '0, '0, 0);
        else if (pv && hv && po == hid)
          add_event(EV_CLICKED, BTN_BITS'(b), 1, po, '0, '0, 0);
        press_ok[b] = 0;
        dragging[b] = 0;
      end
      prev_btn[b] = lv;
    end
    if (scr) add_event(EV_SCROLLED, '0, hv, hid, '0, '0, 0);
    add_event(EV_FRAME_DONE, '0, 0, '0, tx, ty, 1);
  endfunction

  always @(posedge clk_i) begin : check_events
    gesture_ev_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_events.size() == 0) begin
        report($sformatf("unexpected event kind %0d", event_kind_o));
      end else begin
        e = pending_events.pop_front();
        if (event_kind_o != e.kind)
          report($sformatf("kind %0d, want %0d", event_kind_o, e.kind));
        if (button_o != e.btn)
          report($sformatf("button %0d, want %0d", button_o, e.btn));
        if (subject_valid_o != e.sv)
          report($sformatf("subject_valid %0b, want %0b", subject_valid_o, e.sv));
        if (subject_id_o != e.sid)
          report($sformatf("subject_id %0h, want %0h", subject_id_o, e.sid));
        if (drag_total_x_o != e.dx)
          report($sformatf("drag_total_x %0d, want %0d", drag_total_x_o, e.dx));
        if (drag_total_y_o != e.dy)
          report($sformatf("drag_total_y %0d, want %0d", drag_total_y_o, e.dy));
        if (last_o != e.last)
          report($sformatf("last %0b, want %0b", last_o, e.last));
      end
    end
  end

  // receiver side: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 0;
        repeat (400) @(posedge clk_i);
        hold_req = 0;
      end else if (!steady && $urandom_range(0, 24) == 0) begin
        out_ready_i <= 0;
        repeat ($urandom_range(5, 40)) @(posedge clk_i);
      end else begin
        out_ready_i <= steady || ($urandom_range(0, 4) != 0);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(input word_t w);
    int gap;
    in_valid_i     <= 1;
    action_i       <= w.act;
    pointer_x_i    <= w.x;
    pointer_y_i    <= w.y;
    left_level_i   <= w.lv[0];
    right_level_i  <= w.lv[1];
    middle_level_i <= w.lv[2];
    ui_captured_i  <= w.cap;
    hit_valid_i    <= w.hv;
    hit_id_i       <= w.hid;
    scrolled_i     <= w.scr;
    key_code_i     <= w.kc;
    key_level_i    <= w.kl;
    do @(posedge clk_i); while (!in_ready_o);
    predict_events(w);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic word_t mk_frame(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                                     bit [NBTN-1:0] lv, bit hv, logic [ID_BITS-1:0] hid,
                                     bit cap = 0, bit scr = 0);
    word_t w;
    w.act = 0; w.x = x; w.y = y; w.lv = lv; w.cap = cap; w.hv = hv; w.hid = hid;
    w.scr = scr; w.kc = KEY_BITS'($urandom); w.kl = 1'($urandom);
    return w;
  endfunction

  function automatic word_t mk_key(logic [KEY_BITS-1:0] kc, bit kl);
    word_t w;
    w.act = 1; w.x = COORD_BITS'($urandom); w.y = COORD_BITS'($urandom);
    w.lv = NBTN'($urandom); w.cap = 1'($urandom);
    w.hv = 1'($urandom); w.hid = ID_BITS'($urandom); w.scr = 1'($urandom);
    w.kc = kc; w.kl = kl;
    return w;
  endfunction

  task automatic wait_idle();
    in_valid_i <= 0;
    while (pending_events.size() != 0) @(posedge clk_i);
    // key words that make no event may still be in flight
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    wait_idle();
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_ENABLED) cfg_en = data[0];
    else if (idx == CFG_SLOP) cfg_slop = data;
    cfg_valid_i <= 0;
  endtask

  task automatic test_directed();
    // left press on far corner object, drag across the screen, release
    send_word(mk_frame(12'd0, 12'd0, 3'b001, 1, 16'hFFFF));
    send_word(mk_frame(12'd4095, 12'd4095, 3'b001, 1, 16'h0000));
    send_word(mk_frame(12'd4095, 12'd0, 3'b000, 1, 16'hFFFF, 0, 1));
    // right click in place
    send_word(mk_frame(12'd100, 12'd200, 3'b010, 1, 16'h0005));
    send_word(mk_frame(12'd101, 12'd200, 3'b010, 1, 16'h0005));
    send_word(mk_frame(12'd101, 12'd201, 3'b000, 1, 16'h0005));
    // middle press without a hit, then left press without a hit drops focus
    send_word(mk_frame(12'd7, 12'd7, 3'b100, 0, 16'h1234));
    send_word(mk_frame(12'd7, 12'd7, 3'b000, 0, 16'h0000));
    send_word(mk_frame(12'd9, 12'd9, 3'b001, 0, 16'h0001));
    send_word(mk_frame(12'd9, 12'd9, 3'b000, 0, 16'h0000));
    // focus moves between objects: unfocused then focused
    send_word(mk_frame(12'd50, 12'd50, 3'b111, 1, 16'h00AA));
    send_word(mk_frame(12'd50, 12'd50, 3'b000, 1, 16'h00BB));
    send_word(mk_frame(12'd60, 12'd60, 3'b001, 1, 16'h00BB, 0, 1));
    // blind frame while held: release, no click
    send_word(mk_frame(12'd60, 12'd60, 3'b001, 1, 16'h00BB, 1, 1));
    // keys: down, repeated down, up, extremes of the code
    send_word(mk_key(9'd511, 1));
    send_word(mk_key(9'd511, 1));
    send_word(mk_key(9'd511, 0));
    send_word(mk_key(9'd0, 1));
    send_word(mk_key(9'd0, 0));
    send_word(mk_frame(12'd1, 12'd1, 3'b000, 1, 16'h0033, 0, 1));
  endtask

  task automatic test_config();
    write_reg(CFG_SLOP, 12'd0);
    send_word(mk_frame(12'd10, 12'd10, 3'b011, 1, 16'h0042));
    send_word(mk_frame(12'd11, 12'd10, 3'b011, 1, 16'h0042));
    send_word(mk_frame(12'd11, 12'd10, 3'b000, 1, 16'h0042));
    write_reg(CFG_SLOP, 12'd4095);
    send_word(mk_frame(12'd0, 12'd0, 3'b001, 1, 16'h0043));
    send_word(mk_frame(12'd4095, 12'd0, 3'b001, 1, 16'h0043));
    send_word(mk_frame(12'd4095, 12'd4095, 3'b001, 1, 16'h0043));
    write_reg(CFG_ENABLED, 12'd0);
    send_word(mk_frame(12'd5, 12'd5, 3'b111, 1, 16'h0044, 0, 1));
    send_word(mk_key(9'd17, 1));
    send_word(mk_key(9'd17, 0));
    write_reg(CFG_ENABLED, 12'd1);
    write_reg(CFG_SLOP, 12'd4);
    send_word(mk_key(9'd17, 1));
    send_word(mk_frame(12'd5, 12'd5, 3'b000, 1, 16'h0044));
  endtask

  task automatic test_random(input int n_items);
    logic [ID_BITS-1:0] obj_pool [4];
    logic [COORD_BITS-1:0] x0, y0, x, y;
    logic [ID_BITS-1:0] obj;
    bit [NBTN-1:0] mask;
    int sent, moves;
    word_t w;
    foreach (obj_pool[i]) obj_pool[i] = ID_BITS'($urandom);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 15) begin
        w.act = 1'($urandom); w.x = COORD_BITS'($urandom); w.y = COORD_BITS'($urandom);
        w.lv = NBTN'($urandom); w.cap = 1'($urandom); w.hv = 1'($urandom);
        w.hid = ID_BITS'($urandom); w.scr = 1'($urandom);
        w.kc = KEY_BITS'($urandom); w.kl = 1'($urandom);
        send_word(w);
        sent++;
        continue;
      end
      if ($urandom_range(0, 9) == 0) steady = ~steady;
      mask = NBTN'($urandom_range(1, 7));
      obj = obj_pool[$urandom_range(0, 3)];
      x0 = COORD_BITS'($urandom);
      y0 = COORD_BITS'($urandom);
      send_word(mk_frame(x0, y0, mask, $urandom_range(0, 7) != 0, obj, 0,
                         $urandom_range(0, 3) == 0));
      sent++;
      moves = $urandom_range(0, 4);
      for (int i = 0; i < moves; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          x = COORD_BITS'($urandom);
          y = COORD_BITS'($urandom);
        end else begin
          x = COORD_BITS'(x0 + $urandom_range(0, 6));
          y = COORD_BITS'(y0 - $urandom_range(0, 6));
        end
        if ($urandom_range(0, 4) == 0)
          send_word(mk_key(9'($urandom_range(0, 3)), 1'($urandom)));
        else
          send_word(mk_frame(x, y, mask, 1, obj, $urandom_range(0, 19) == 0,
                             $urandom_range(0, 3) == 0));
        sent++;
      end
      send_word(mk_frame(x0, y0, $urandom_range(0, 3) == 0 ? NBTN'($urandom) : '0,
                         $urandom_range(0, 9) != 0,
                         $urandom_range(0, 9) < 6 ? obj : obj_pool[$urandom_range(0, 3)],
                         0, $urandom_range(0, 3) == 0));
      sent++;
    end
    steady = 0;
  endtask

  task automatic test_backpressure();
    hold_req = 1;
    steady = 1;
    for (int i = 0; i < 24; i++)
      send_word(mk_frame(COORD_BITS'($urandom), COORD_BITS'($urandom), NBTN'(i), 1,
                         16'h0077, 0, 1));
    steady = 0;
    wait_idle();
  endtask

  initial begin
    foreach (prev_btn[b]) begin
      prev_btn[b] = 0; press_x[b] = '0; press_y[b] = '0; press_obj[b] = '0;
      press_ok[b] = 0; dragging[b] = 0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    test_directed();
    test_config();
    test_backpressure();
    test_random(200);
    write_reg(CFG_SLOP, 12'd1);
    test_random(25);
    wait_idle();
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("pointer_click_drag_recognizer_tb passed");
    end else begin
      $display("pointer_click_drag_recognizer_tb failed");
    end
    $finish;
  end

endmodule
